// ===== hdl/blr_pkg.sv =====
// Shared types and constants for the line rasterizer.
package blr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int COLOR_BITS  = 32;
  // The error term stays within plus or minus 2 * 2^COORD_BITS.
  localparam int ERR_BITS    = COORD_BITS + 3;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                   operation;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] draw_color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_value;
    logic                  last_pixel;
  } out_item_t;

  // Classified command handed from the front end to the walker.
  typedef struct packed {
    op_t                   op;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y1;
    logic [COORD_BITS-1:0] x2;
    logic [COORD_BITS-1:0] y2;
    logic [COORD_BITS-1:0] abs_dx;
    logic [COORD_BITS-1:0] abs_dy;
    logic                  dx_neg;
    logic                  dy_neg;
    logic                  minor_up;
    logic [COLOR_BITS-1:0] color;
  } cmd_t;

endpackage

// ===== hdl/bresenham_line_rasterizer_core.sv =====
// Top level of the line rasterizer: front end, command queue and walker.
//
// Input channel (in_valid, in_ready, in_data): one beat per command. A start
// beat (operation 0) loads two endpoints and a colour and yields the first
// pixel of the line; a step beat (operation 1) yields the next pixel. A step
// beat while no line is active is consumed and yields nothing. A start beat
// during a line drops that line.
// Output channel (out_valid, out_ready, out_data): one beat per pixel, with
// last_pixel set on the final pixel of the line.
// A command beat passes the front register, the queue and the output
// register before its pixel is presented. Throughput is one command and
// one pixel per cycle while the output does not stall; each walker step is
// one error update and one end compare. A stall on the output holds the
// output register; the two-entry queue and the front register keep taking
// input beats until all three are full, then in_ready drops.
// Reset (rst_n low at a clock edge) empties the queue and the output
// register and leaves no line active.
module bresenham_line_rasterizer_core #(
  parameter int QUEUE_DEPTH = blr_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  blr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output blr_pkg::out_item_t out_data
);

  logic          f_valid;
  logic          f_ready;
  blr_pkg::cmd_t f_cmd;
  logic          q_valid;
  logic          q_ready;
  blr_pkg::cmd_t q_cmd;

  blr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_cmd)
  );

  blr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  blr_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd_data  (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/blr_front.sv =====
// Front end: accepts input beats, works out the line deltas and registers a command.
module blr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  blr_pkg::in_item_t in_data,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output blr_pkg::cmd_t    cmd_data
);

  localparam int CB = blr_pkg::COORD_BITS;

  logic          valid_r;
  blr_pkg::cmd_t cmd_r;
  blr_pkg::cmd_t cmd_nxt;
  logic [CB:0]   dx;
  logic [CB:0]   dy;
  logic [CB:0]   dx_mag;
  logic [CB:0]   dy_mag;
  logic          dx_zero;
  logic          dy_zero;

  always_comb begin
    dx      = {1'b0, in_data.end_x} - {1'b0, in_data.start_x};
    dy      = {1'b0, in_data.end_y} - {1'b0, in_data.start_y};
    dx_mag  = dx[CB] ? (~dx + {{CB{1'b0}}, 1'b1}) : dx;
    dy_mag  = dy[CB] ? (~dy + {{CB{1'b0}}, 1'b1}) : dy;
    dx_zero = (dx == '0);
    dy_zero = (dy == '0);

    cmd_nxt.op       = in_data.operation;
    cmd_nxt.x1       = in_data.start_x;
    cmd_nxt.y1       = in_data.start_y;
    cmd_nxt.x2       = in_data.end_x;
    cmd_nxt.y2       = in_data.end_y;
    cmd_nxt.abs_dx   = dx_mag[CB-1:0];
    cmd_nxt.abs_dy   = dy_mag[CB-1:0];
    cmd_nxt.dx_neg   = dx[CB];
    cmd_nxt.dy_neg   = dy[CB];
    // The minor axis moves up only when both deltas share a strict sign.
    cmd_nxt.minor_up = (dx[CB] && dy[CB]) ||
                       (!dx[CB] && !dx_zero && !dy[CB] && !dy_zero);
    cmd_nxt.color    = in_data.draw_color;
  end

  assign in_ready  = !valid_r || cmd_ready;
  assign cmd_valid = valid_r;
  assign cmd_data  = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== hdl/blr_queue.sv =====
// Short command queue between the front end and the walker.
module blr_queue #(
  parameter int DEPTH = blr_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  blr_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output blr_pkg::cmd_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  blr_pkg::cmd_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != FULL_CNT);
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("queue fill count beyond depth");

endmodule

// ===== hdl/blr_walk.sv =====
// Back end: holds the line state, steps the error term and registers each pixel.
module blr_walk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  blr_pkg::cmd_t      cmd_data,
  output logic               out_valid,
  input  logic               out_ready,
  output blr_pkg::out_item_t out_data
);

  localparam int CB = blr_pkg::COORD_BITS;
  localparam int EB = blr_pkg::ERR_BITS;
  localparam logic signed [EB-1:0] ERR_LIM = EB'(2 ** (CB + 1));

  logic                     busy_r;
  logic                     major_x_r;
  logic                     minor_up_r;
  logic [CB-1:0]            cur_x_r;
  logic [CB-1:0]            cur_y_r;
  logic [CB-1:0]            major_end_r;
  logic signed [EB-1:0]     inc_keep_r;
  logic signed [EB-1:0]     inc_move_r;
  logic signed [EB-1:0]     err_r;
  logic [blr_pkg::COLOR_BITS-1:0] color_r;
  logic                     out_valid_r;
  blr_pkg::out_item_t       out_r;

  logic                     advance;
  logic                     pop;
  logic                     is_start;

  // Start set-up.
  logic                     s_major_x;
  logic                     s_from_first;
  logic [CB-1:0]            s_maj_abs;
  logic [CB-1:0]            s_min_abs;
  logic [CB-1:0]            s_x;
  logic [CB-1:0]            s_y;
  logic [CB-1:0]            s_end;
  logic signed [EB-1:0]     s_keep;
  logic signed [EB-1:0]     s_move;
  logic signed [EB-1:0]     s_err;
  logic                     s_last;

  // One step of the walk.
  logic                     t_move;
  logic [CB-1:0]            t_minor_delta;
  logic [CB-1:0]            t_x;
  logic [CB-1:0]            t_y;
  logic signed [EB-1:0]     t_err;
  logic                     t_last;

  assign advance   = !out_valid_r || out_ready;
  assign cmd_ready = advance;
  assign pop       = cmd_valid && advance;
  assign is_start  = (cmd_data.op == blr_pkg::OP_START);

  always_comb begin
    s_major_x    = (cmd_data.abs_dy <= cmd_data.abs_dx);
    s_maj_abs    = s_major_x ? cmd_data.abs_dx : cmd_data.abs_dy;
    s_min_abs    = s_major_x ? cmd_data.abs_dy : cmd_data.abs_dx;
    s_from_first = s_major_x ? !cmd_data.dx_neg : !cmd_data.dy_neg;
    s_x          = s_from_first ? cmd_data.x1 : cmd_data.x2;
    s_y          = s_from_first ? cmd_data.y1 : cmd_data.y2;
    if (s_major_x) begin
      s_end = s_from_first ? cmd_data.x2 : cmd_data.x1;
    end else begin
      s_end = s_from_first ? cmd_data.y2 : cmd_data.y1;
    end
    s_keep = $signed({2'b00, s_min_abs, 1'b0});
    s_move = s_keep - $signed({2'b00, s_maj_abs, 1'b0});
    s_err  = s_keep - $signed({3'b000, s_maj_abs});
    // The walk starts at the smaller major end, so it is over at once
    // exactly when the major delta is zero.
    s_last = (s_maj_abs == '0);
  end

  always_comb begin
    // x-major moves the minor axis on a non-negative error, y-major only on
    // a strictly positive one.
    t_move        = !err_r[EB-1] && (major_x_r || (err_r != '0));
    t_minor_delta = minor_up_r ? CB'(1) : {CB{1'b1}};
    t_err         = t_move ? (err_r + inc_move_r) : (err_r + inc_keep_r);
    if (major_x_r) begin
      t_x    = cur_x_r + CB'(1);
      t_y    = t_move ? (cur_y_r + t_minor_delta) : cur_y_r;
      t_last = (t_x == major_end_r);
    end else begin
      t_y    = cur_y_r + CB'(1);
      t_x    = t_move ? (cur_x_r + t_minor_delta) : cur_x_r;
      t_last = (t_y == major_end_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= pop && (is_start || busy_r);
      end
      if (pop) begin
        if (is_start) begin
          busy_r <= !s_last;
        end else if (busy_r) begin
          busy_r <= !t_last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (is_start) begin
        major_x_r         <= s_major_x;
        minor_up_r        <= cmd_data.minor_up;
        cur_x_r           <= s_x;
        cur_y_r           <= s_y;
        major_end_r       <= s_end;
        inc_keep_r        <= s_keep;
        inc_move_r        <= s_move;
        err_r             <= s_err;
        color_r           <= cmd_data.color;
        out_r.pixel_x     <= s_x;
        out_r.pixel_y     <= s_y;
        out_r.pixel_value <= cmd_data.color;
        out_r.last_pixel  <= s_last;
      end else if (busy_r) begin
        cur_x_r           <= t_x;
        cur_y_r           <= t_y;
        err_r             <= t_err;
        out_r.pixel_x     <= t_x;
        out_r.pixel_y     <= t_y;
        out_r.pixel_value <= color_r;
        out_r.last_pixel  <= t_last;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_pixel_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pop))
    else $error("pixel appeared without a command being taken");

  a_busy_short_of_end: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((major_x_r ? cur_x_r : cur_y_r) != major_end_r))
    else $error("line still active at its far end");

  a_err_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (err_r <= ERR_LIM && err_r >= -ERR_LIM))
    else $error("error term out of range");

endmodule
